// ----- src/ccm_pkg.sv -----
// Shared constants, types and constant tables of the sRGB color correction matrix.
// The degamma table and the regamma decision points are computed at elaboration.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ccm_pkg;

  // Fixed-point formats.
  localparam int LINEAR_FRAC_BITS   = 15;
  localparam int COEFF_FRAC_BITS    = 10;
  localparam int REGAMMA_INDEX_BITS = 14;

  localparam int CHANNELS  = 3;
  localparam int BYTE_W    = 8;
  localparam int TDATA_W   = 4 * BYTE_W;
  localparam int COEFF_W   = 15;
  localparam int ROW_W     = CHANNELS * COEFF_W;
  localparam int CFG_IDX_W = 2;

  // Linear values reach exactly 1.0, so one integer bit is needed.
  localparam int LIN_W     = LINEAR_FRAC_BITS + 1;
  localparam int PROD_W    = LIN_W + 1 + COEFF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SUM_SHIFT = LINEAR_FRAC_BITS + COEFF_FRAC_BITS - REGAMMA_INDEX_BITS;

  // Regamma is a search over the 255 decision points of the output codes.
  localparam int Q30_BITS     = 30;
  localparam int DEC_W        = Q30_BITS + 1;
  localparam int DEC_N        = 255;
  localparam int X_W          = Q30_BITS;
  localparam int X_SHIFT      = Q30_BITS - 1 - REGAMMA_INDEX_BITS;
  localparam int SEARCH_STEPS = BYTE_W;

  // Pipeline: degamma stage, product stage, sum stage, search stages, output stage.
  localparam int LANE_STAGES = 2 + SEARCH_STEPS;
  localparam int NSTG        = LANE_STAGES + 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BLUE  = 2'd2;

  // Identity rows after reset.
  localparam logic [ROW_W-1:0] ROW_RED_RESET   = ROW_W'(1) << COEFF_FRAC_BITS;
  localparam logic [ROW_W-1:0] ROW_GREEN_RESET = ROW_W'(1) << (COEFF_FRAC_BITS + COEFF_W);
  localparam logic [ROW_W-1:0] ROW_BLUE_RESET  = ROW_W'(1) << (COEFF_FRAC_BITS + 2 * COEFF_W);

  typedef logic [CHANNELS-1:0][LIN_W-1:0] lin_vec_t;
  typedef logic [DEC_W-1:0] decision_tab_t [DEC_N];
  typedef logic [LIN_W-1:0] degamma_tab_t [256];

  // Per-stage load strobes shared by the pipeline stages.
  typedef struct packed {
    logic [NSTG-1:0] load;
  } ccm_ctrl_t;

  // Fractions are taken over a fixed denominator of 510.
  localparam longint unsigned DEN     = 510;
  localparam longint unsigned ONE_Q30 = 64'd1 << Q30_BITS;

  function automatic longint unsigned pow5_q30(input longint unsigned r);
    longint unsigned p;
    p = r;
    for (int k = 0; k < 4; k++) begin
      p = (p * r) >> Q30_BITS;
    end
    return p;
  endfunction

  // Largest root whose fifth power stays at or below v.
  function automatic longint unsigned root5_q30(input longint unsigned v);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = ONE_Q30;
    for (int it = 0; it < 40; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        if (pow5_q30(mid) <= v) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return lo;
  endfunction

  // Linear light of the sRGB fraction num/510 in Q30.
  function automatic longint unsigned linear_q30(input longint unsigned num);
    longint unsigned y;
    longint unsigned y2;
    longint unsigned res;
    if (100000 * num < 4045 * DEN) begin
      res = ((num << Q30_BITS) * 100) / (DEN * 1292);
    end else begin
      y = ((1000 * num + 55 * DEN) << Q30_BITS) / (1055 * DEN);
      if (y > ONE_Q30) begin
        y = ONE_Q30;
      end
      y2  = (y * y) >> Q30_BITS;
      res = (y2 * root5_q30(y2)) >> Q30_BITS;
    end
    return res;
  endfunction

  function automatic degamma_tab_t build_degamma();
    degamma_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = LIN_W'(linear_q30(64'(2 * i)) >> (Q30_BITS - LINEAR_FRAC_BITS));
    end
    return t;
  endfunction

  function automatic decision_tab_t build_decision();
    decision_tab_t t;
    for (int i = 0; i < DEC_N; i++) begin
      t[i] = DEC_W'(linear_q30(64'(2 * i + 1)));
    end
    return t;
  endfunction

  localparam degamma_tab_t  DEGAMMA_ROM  = build_degamma();
  localparam decision_tab_t DECISION_TAB = build_decision();

endpackage

`default_nettype wire

// ----- src/ccm_degamma.sv -----
// Input stage: linearizes the three color bytes of an item through the degamma table.
// Depends on ccm_pkg for the table and the formats.
`timescale 1ns / 1ps
`default_nettype none

module ccm_degamma import ccm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [TDATA_W-1:0] pix,
  output lin_vec_t                lin,
  output logic      [BYTE_W-1:0]  alpha
);

  // Three table reads side by side, alpha rides along.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lin[c] <= DEGAMMA_ROM[pix[c*BYTE_W +: BYTE_W]];
      end
      alpha <= pix[CHANNELS*BYTE_W +: BYTE_W];
    end
  end

endmodule

`default_nettype wire

// ----- src/ccm_lane.sv -----
// One output channel: three products, sum, range check and regamma search.
// Depends on ccm_pkg for formats, the decision table and the stage control type.
`timescale 1ns / 1ps
`default_nettype none

module ccm_lane import ccm_pkg::*; (
  input  wire logic              clk,
  input  wire ccm_ctrl_t         ctrl,
  input  wire lin_vec_t          lin,
  input  wire logic [ROW_W-1:0]  row,
  output logic      [BYTE_W-1:0] code
);

  logic signed [PROD_W-1:0]             prod_q [CHANNELS];
  logic signed [SUM_W-1:0]              sum;
  logic                                 neg;
  logic                                 over;
  logic                                 zero;
  logic [REGAMMA_INDEX_BITS-1:0]        idx;
  logic [X_W-1:0]                       x;
  logic [X_W-1:0]                       x2_q;
  logic                                 zero2_q;
  logic                                 over2_q;
  logic [BYTE_W-1:0]                    c_q    [SEARCH_STEPS];
  logic                                 zero_q [SEARCH_STEPS];
  logic                                 over_q [SEARCH_STEPS];
  logic [X_W-1:0]                       x_q    [SEARCH_STEPS-1];

  // Exact products of unsigned linear values with signed coefficients.
  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prod_q[c] <= $signed({1'b0, lin[c]}) * $signed(row[c*COEFF_W +: COEFF_W]);
      end
    end
  end

  // Sum, classify and form the search point (2*idx - 1) in Q30.
  always_comb begin
    sum = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sum = sum + SUM_W'(prod_q[c]);
    end
    neg  = sum[SUM_W-1];
    idx  = sum[SUM_SHIFT +: REGAMMA_INDEX_BITS];
    over = !neg && (|sum[SUM_W-2:SUM_SHIFT+REGAMMA_INDEX_BITS]);
    zero = neg || (!over && (idx == '0));
    x    = X_W'({idx - 1'b1, 1'b1}) << X_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      x2_q    <= x;
      zero2_q <= zero;
      over2_q <= over;
    end
  end

  // Binary search, one code bit per stage: count of decision points at or below x.
  for (genvar s = 0; s < SEARCH_STEPS; s++) begin : g_step
    logic [BYTE_W-1:0] c_in;
    logic [BYTE_W-1:0] probe;
    logic [X_W-1:0]    x_in;
    logic              zero_in;
    logic              over_in;
    logic              take;

    if (s == 0) begin : g_first
      assign c_in    = '0;
      assign x_in    = x2_q;
      assign zero_in = zero2_q;
      assign over_in = over2_q;
    end else begin : g_next
      assign c_in    = c_q[s-1];
      assign x_in    = x_q[s-1];
      assign zero_in = zero_q[s-1];
      assign over_in = over_q[s-1];
    end

    assign probe = c_in | BYTE_W'(1 << (SEARCH_STEPS - 1 - s));
    assign take  = DECISION_TAB[probe - 1'b1] <= DEC_W'(x_in);

    always_ff @(posedge clk) begin
      if (ctrl.load[3+s]) begin
        c_q[s]    <= take ? probe : c_in;
        zero_q[s] <= zero_in;
        over_q[s] <= over_in;
      end
    end

    if (s < SEARCH_STEPS - 1) begin : g_x
      always_ff @(posedge clk) begin
        if (ctrl.load[3+s]) begin
          x_q[s] <= x_in;
        end
      end
    end
  end

  // Negative sums and sums at index zero give black, sums past the table give full scale.
  assign code = zero_q[SEARCH_STEPS-1] ? '0 :
                over_q[SEARCH_STEPS-1] ? '1 : c_q[SEARCH_STEPS-1];

endmodule

`default_nettype wire

// ----- src/ccm_merge.sv -----
// Output stage: joins the three lane codes and the delayed alpha into one item.
// Depends on ccm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ccm_merge import ccm_pkg::*; (
  input  wire logic                             clk,
  input  wire logic                             load,
  input  wire logic [CHANNELS-1:0][BYTE_W-1:0]  codes,
  input  wire logic [BYTE_W-1:0]                alpha,
  output logic      [TDATA_W-1:0]               tdata
);

  // Red in the lowest byte, alpha in the highest.
  always_ff @(posedge clk) begin
    if (load) begin
      tdata <= {alpha, codes[2], codes[1], codes[0]};
    end
  end

endmodule

`default_nettype wire

// ----- src/srgb_color_correction_matrix.sv -----
// Top level of the sRGB color correction matrix: pipeline control, matrix rows, lanes.
// Depends on ccm_pkg, ccm_degamma, ccm_lane and ccm_merge.
//
//   channel  direction  handshake              payload
//   s_*      in         s_tvalid / s_tready    s_tdata: red, green, blue, alpha bytes
//   m_*      out        m_tvalid / m_tready    m_tdata: red, green, blue, alpha bytes
//   cfg_*    in         cfg_we                 cfg_index, cfg_data (one 45-bit row)
//
// One item per clock is accepted and delivered while the output is not stalled.
// The stages are degamma, products, sum, eight search stages of the regamma
// lookup (one output code bit each) and the output register.
// Each stage holds its item only while the one after it is full and stalled,
// so bubbles close up and input keeps flowing while a result waits.
// Reset (rst, synchronous) empties the pipeline and loads identity rows.

`timescale 1ns / 1ps
`default_nettype none

module srgb_color_correction_matrix import ccm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [TDATA_W-1:0]   s_tdata,   // red 7:0, green 15:8, blue 23:16, alpha 31:24
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [TDATA_W-1:0]   m_tdata,   // red 7:0, green 15:8, blue 23:16, alpha 31:24
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ROW_W-1:0]     cfg_data
);

  logic [ROW_W-1:0]                row_q [CHANNELS];
  logic [NSTG-1:0]                 v_q;
  logic [NSTG-1:0]                 rdy;
  ccm_ctrl_t                       ctrl;
  lin_vec_t                        lin;
  logic [BYTE_W-1:0]               alpha0;
  logic [BYTE_W-1:0]               alpha_dly [LANE_STAGES];
  logic [CHANNELS-1:0][BYTE_W-1:0] codes;

  // Matrix rows; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_q[0] <= ROW_RED_RESET;
      row_q[1] <= ROW_GREEN_RESET;
      row_q[2] <= ROW_BLUE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_RED:   row_q[0] <= cfg_data;
        REG_ROW_GREEN: row_q[1] <= cfg_data;
        REG_ROW_BLUE:  row_q[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its successor moves on.
  always_comb begin
    rdy[NSTG-1] = !v_q[NSTG-1] || m_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    ctrl.load = rdy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = v_q[NSTG-1];

  ccm_degamma u_degamma (
    .clk   (clk),
    .load  (ctrl.load[0]),
    .pix   (s_tdata),
    .lin   (lin),
    .alpha (alpha0)
  );

  // Alpha follows the lanes through the same number of stages.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      alpha_dly[0] <= alpha0;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (rdy[k+1]) begin
        alpha_dly[k] <= alpha_dly[k-1];
      end
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    ccm_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .lin  (lin),
      .row  (row_q[c]),
      .code (codes[c])
    );
  end

  ccm_merge u_merge (
    .clk   (clk),
    .load  (ctrl.load[NSTG-1]),
    .codes (codes),
    .alpha (alpha_dly[LANE_STAGES-1]),
    .tdata (m_tdata)
  );

  // A ready sink never holds back the source.
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is ready");

  // A full pipeline with a stalled sink takes nothing more.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && (&v_q)) |-> !s_tready)
    else $error("item accepted into a full stalled pipeline");

  // An accepted item occupies the first stage on the next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v_q[0])
    else $error("accepted item lost at the first stage");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the sRGB color correction matrix.
// Depends on ccm_pkg and srgb_color_correction_matrix; predicts every pixel bit for bit.
// A directed table comes first, then random phases, each under its own matrix.
`timescale 1ns / 1ps

module testbench;
  import ccm_pkg::*;

  localparam int IDLE_PCT      = 29;
  localparam int LATENCY       = 12;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 235;
  localparam int STEADY_PHASE  = 2;
  localparam int TIMEOUT_NS    = 400_000;
  localparam int REGAMMA_SIZE  = 1 << REGAMMA_INDEX_BITS;
  localparam int COEFF_MAX     = (1 << (COEFF_W - 1)) - 1;
  localparam int COEFF_MIN     = -(1 << (COEFF_W - 1));

  // The port decodes two index bits, but only three rows exist.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Extreme rows: every coefficient at its most negative, most positive, or -1.
  localparam logic [ROW_W-1:0] ROW_MIN_ALL  = {CHANNELS{15'h4000}};
  localparam logic [ROW_W-1:0] ROW_MAX_ALL  = {CHANNELS{15'h3FFF}};
  localparam logic [ROW_W-1:0] ROW_NEG_ONES = '1;

  // Same layout as tdata: red in the lowest byte, alpha in the highest.
  typedef struct packed {
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } pixel_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_e;

  typedef struct packed {
    step_e                kind;
    logic [CFG_IDX_W-1:0] index;
    logic [ROW_W-1:0]     value;
    pixel_t               pix;
    logic                 typed;
    pixel_t               want;
  } plan_step_t;

  typedef enum {STYLE_IDENTITY, STYLE_NATURAL, STYLE_WILD, STYLE_RAW} row_style_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata = '0;   // red 7:0, green 15:8, blue 23:16, alpha 31:24
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;        // red 7:0, green 15:8, blue 23:16, alpha 31:24
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_data = '0;

  // Predictor state: transfer tables and a copy of the three matrix rows.
  int unsigned      degamma_lut [256];
  logic [BYTE_W-1:0] regamma_lut [REGAMMA_SIZE];
  logic [ROW_W-1:0] row_shadow [CHANNELS];

  pixel_t corrected_q [$];
  int     mismatches = 0;
  bit     steady_flow = 1'b0;
  string  field_names [4];

  srgb_color_correction_matrix dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Linear light of the sRGB fraction num/den in Q30, integer only.
  function automatic longint unsigned srgb_to_linear(longint unsigned num,
                                                     longint unsigned den);
    longint unsigned y;
    longint unsigned y2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    if (100000 * num < 4045 * den) begin
      return ((num << Q30_BITS) * 100) / (den * 1292);
    end
    y = ((1000 * num + 55 * den) << Q30_BITS) / (1055 * den);
    if (y > ONE_Q30) y = ONE_Q30;
    y2 = (y * y) >> Q30_BITS;
    // x^2.4 is x^2 times the fifth root of x^2; the root is found by bisection.
    lo = 0;
    hi = ONE_Q30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      p = mid;
      repeat (4) p = (p * mid) >> Q30_BITS;
      if (p <= y2) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return (y2 * lo) >> Q30_BITS;
  endfunction

  // Expected output pixel under the current matrix.
  function automatic pixel_t correct_pixel(pixel_t p);
    longint                    lin [CHANNELS];
    longint                    acc;
    logic signed [COEFF_W-1:0] coeff;
    pixel_t                    q;
    lin[0] = longint'(degamma_lut[p.red]);
    lin[1] = longint'(degamma_lut[p.green]);
    lin[2] = longint'(degamma_lut[p.blue]);
    q = p;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      acc = 0;
      for (int s = 0; s < CHANNELS; s++) begin
        coeff = row_shadow[ch][s*COEFF_W +: COEFF_W];
        acc += lin[s] * longint'(coeff);
      end
      // Negative sums clamp to black, sums past the table clamp to full scale.
      if (acc < 0) begin
        q[ch*BYTE_W +: BYTE_W] = 8'd0;
      end else if ((acc >>> SUM_SHIFT) >= REGAMMA_SIZE) begin
        q[ch*BYTE_W +: BYTE_W] = 8'd255;
      end else begin
        q[ch*BYTE_W +: BYTE_W] = regamma_lut[acc >>> SUM_SHIFT];
      end
    end
    return q;
  endfunction

  function automatic pixel_t rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic [7:0] a);
    return {a, b, g, r};
  endfunction

  function automatic plan_step_t pixel_step(pixel_t pix, logic typed, pixel_t want);
    return {STEP_PIXEL, REG_ROW_RED, {ROW_W{1'b0}}, pix, typed, want};
  endfunction

  function automatic plan_step_t write_step(logic [CFG_IDX_W-1:0] index,
                                            logic [ROW_W-1:0] value);
    return {STEP_WRITE, index, value, {TDATA_W{1'b0}}, 1'b0, {TDATA_W{1'b0}}};
  endfunction

  // One matrix row; diag is the slot of the channel's own input.
  function automatic logic [ROW_W-1:0] pick_row(int diag, row_style_e style);
    logic [ROW_W-1:0] row;
    int               c;
    row = '0;
    for (int s = 0; s < CHANNELS; s++) begin
      case (style)
        STYLE_IDENTITY: c = (s == diag) ? (1 << COEFF_FRAC_BITS) : 0;
        STYLE_NATURAL: begin
          if (s == diag) begin
            c = int'($urandom_range(1536, 512));
          end else begin
            c = int'($urandom_range(800, 0)) - 400;
          end
        end
        STYLE_WILD: begin
          case ($urandom_range(4, 0))
            0: c = COEFF_MAX;
            1: c = COEFF_MIN;
            2: c = 0;
            3: c = -1;
            default: c = int'($urandom);
          endcase
        end
        default: c = int'($urandom);
      endcase
      row[s*COEFF_W +: COEFF_W] = c[COEFF_W-1:0];
    end
    return row;
  endfunction

  // Stops input and waits until every expected pixel has come back.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk);
  endtask

  // Writes one register once the block is idle; cfg_we is left high.
  task automatic program_row(input logic [CFG_IDX_W-1:0] index,
                             input logic [ROW_W-1:0] value);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    if (index != REG_SPARE) row_shadow[index] = value;
  endtask

  // Offers one item, after a random gap unless the flow is steady, and records its expected result.
  task automatic push_pixel(input pixel_t pix, input logic typed, input pixel_t want);
    cfg_we <= 1'b0;
    while (!steady_flow && $urandom_range(99, 0) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    corrected_q.push_back(typed ? want : correct_pixel(pix));
  endtask

  // Transfer tables and reset matrix, ready long before reset is released.
  initial begin : table_build
    longint unsigned decision_pts [255];
    longint unsigned x;
    int unsigned     code;
    field_names = '{"red", "green", "blue", "alpha"};
    row_shadow[0] = ROW_RED_RESET;
    row_shadow[1] = ROW_GREEN_RESET;
    row_shadow[2] = ROW_BLUE_RESET;
    for (int i = 0; i < 256; i++) begin
      degamma_lut[i] = int'(srgb_to_linear(i, 255) >> (Q30_BITS - LINEAR_FRAC_BITS));
    end
    // Decision points sit halfway between neighboring output codes.
    for (int i = 0; i < 255; i++) begin
      decision_pts[i] = srgb_to_linear(2 * i + 1, 510);
    end
    regamma_lut[0] = 8'd0;
    code = 0;
    for (int j = 1; j < REGAMMA_SIZE; j++) begin
      x = longint'(2 * j - 1) << (Q30_BITS - 1 - REGAMMA_INDEX_BITS);
      while (code < 255 && decision_pts[code] <= x) code++;
      regamma_lut[j] = BYTE_W'(code);
    end
  end

  // Output side: random backpressure and in-order comparison.
  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (corrected_q.size() == 0) begin
          $display("%0t: unexpected item %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = corrected_q.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (want[f*BYTE_W +: BYTE_W] !== m_tdata[f*BYTE_W +: BYTE_W]) begin
              $display("%0t: %s expected %0d, got %0d", $time, field_names[f],
                       want[f*BYTE_W +: BYTE_W], m_tdata[f*BYTE_W +: BYTE_W]);
              mismatches++;
            end
          end
        end
      end
      m_tready <= steady_flow || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    plan_step_t plan [$];
    pixel_t     pix;
    row_style_e style;

    // Identity matrix after reset: pure black, white and primaries come back as is.
    plan.push_back(pixel_step(rgba(8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                              rgba(8'h00, 8'h00, 8'h00, 8'h00)));
    plan.push_back(pixel_step(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                              rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF)));
    plan.push_back(pixel_step(rgba(8'hFF, 8'h00, 8'h00, 8'h5A), 1'b1,
                              rgba(8'hFF, 8'h00, 8'h00, 8'h5A)));
    plan.push_back(pixel_step(rgba(8'h00, 8'hFF, 8'h00, 8'hA5), 1'b1,
                              rgba(8'h00, 8'hFF, 8'h00, 8'hA5)));
    plan.push_back(pixel_step(rgba(8'h00, 8'h00, 8'hFF, 8'h3C), 1'b1,
                              rgba(8'h00, 8'h00, 8'hFF, 8'h3C)));
    // Codes around the knee between the linear segment and the power curve, then low, middle and high codes.
    plan.push_back(pixel_step(rgba(8'h0A, 8'h0B, 8'h0C, 8'hC3), 1'b0, '0));
    plan.push_back(pixel_step(rgba(8'h01, 8'h80, 8'hFE, 8'h81), 1'b0, '0));
    // A write to the unused index must leave the matrix alone.
    plan.push_back(write_step(REG_SPARE, '1));
    plan.push_back(pixel_step(rgba(8'hFF, 8'h00, 8'h00, 8'h00), 1'b1,
                              rgba(8'hFF, 8'h00, 8'h00, 8'h00)));
    // Extreme rows: red at the most negative coefficients, green at the most positive, blue zero.
    plan.push_back(write_step(REG_ROW_RED, ROW_MIN_ALL));
    plan.push_back(write_step(REG_ROW_GREEN, ROW_MAX_ALL));
    plan.push_back(write_step(REG_ROW_BLUE, '0));
    plan.push_back(pixel_step(rgba(8'hFF, 8'hFF, 8'hFF, 8'h07), 1'b1,
                              rgba(8'h00, 8'hFF, 8'h00, 8'h07)));
    plan.push_back(pixel_step(rgba(8'h00, 8'h00, 8'h00, 8'hFF), 1'b1,
                              rgba(8'h00, 8'h00, 8'h00, 8'hFF)));
    plan.push_back(pixel_step(rgba(8'h01, 8'h02, 8'h03, 8'h10), 1'b0, '0));
    // All -1 on red; plausible mixes with negative terms on green and blue.
    plan.push_back(write_step(REG_ROW_RED, ROW_NEG_ONES));
    plan.push_back(write_step(REG_ROW_GREEN, {15'd0, 15'd1536, 15'h7E00}));
    plan.push_back(write_step(REG_ROW_BLUE, {15'd1200, 15'h7F00, 15'd100}));
    plan.push_back(pixel_step(rgba(8'hFF, 8'hFF, 8'hFF, 8'h20), 1'b0, '0));
    plan.push_back(pixel_step(rgba(8'h40, 8'h80, 8'hC0, 8'h30), 1'b0, '0));
    plan.push_back(pixel_step(rgba(8'h7F, 8'h7F, 8'h7F, 8'hE0), 1'b0, '0));
    plan.push_back(pixel_step(rgba(8'hFF, 8'h20, 8'h00, 8'h01), 1'b0, '0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        program_row(plan[i].index, plan[i].value);
      end else begin
        push_pixel(plan[i].pix, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each with a fresh matrix; one phase runs without any idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: style = STYLE_IDENTITY;
        3: style = STYLE_RAW;
        5: style = STYLE_WILD;
        default: style = STYLE_NATURAL;
      endcase
      program_row(REG_ROW_RED, pick_row(0, style));
      program_row(REG_ROW_GREEN, pick_row(1, style));
      program_row(REG_ROW_BLUE, pick_row(2, style));
      if ($urandom_range(3, 0) == 0) program_row(REG_SPARE, ROW_W'({$urandom, $urandom}));
      steady_flow <= (ph == STEADY_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        for (int f = 0; f < 4; f++) begin
          case ($urandom_range(9, 0))
            0: pix[f*BYTE_W +: BYTE_W] = 8'h00;
            1: pix[f*BYTE_W +: BYTE_W] = 8'hFF;
            default: pix[f*BYTE_W +: BYTE_W] = BYTE_W'($urandom);
          endcase
        end
        push_pixel(pix, 1'b0, '0);
      end
    end

    drain_pipeline();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- srgb_color_correction_matrix.f -----
src/ccm_pkg.sv
src/ccm_degamma.sv
src/ccm_lane.sv
src/ccm_merge.sv
src/srgb_color_correction_matrix.sv
tb/sv/testbench.sv
